### design/mspfp_pkg.sv
// shared constants and the crc-8 step for the msp frame parser
package mspfp_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharM      = 8'h4D;
  localparam logic [7:0] CharX      = 8'h58;
  localparam logic [7:0] CharGt     = 8'h3E;

  localparam logic [7:0] Crc8Poly   = 8'hD5;

  // crc-8 dvb-s2, one byte folded in, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ Crc8Poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/msp_frame_parser.sv
// top level of the msp v1/v2 response frame parser
// Takes one received byte per word and returns one word per byte: frame_ok_o is
// high on the checksum byte of a '$M>' or '$X>' frame whose xor (v1) or crc-8
// dvb-s2 (v2) check matches and whose payload fits in MAX_PAYLOAD bytes. A byte
// goes through an input register, combinational parse logic (state machine and
// byte-wide crc step) and a result register, and a new byte is taken every
// cycle while the result side keeps up. Payload bytes of frames that fit are
// written into an internal store of MAX_PAYLOAD bytes.
module msp_frame_parser
  import mspfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_ok_o
);

  localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  logic             ok_q;
  logic             advance;
  logic             in_take;
  logic             step_ok;
  logic             store_we;
  logic [AddrW-1:0] store_addr;
  logic [7:0]       store_data;

  // parse step runs when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  mspfp_parse_core #(
    .MaxPayload (MAX_PAYLOAD),
    .AddrW      (AddrW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .ok_o         (step_ok),
    .store_we_o   (store_we),
    .store_addr_o (store_addr),
    .store_data_o (store_data)
  );

  mspfp_payload_store #(
    .Depth (MAX_PAYLOAD),
    .AddrW (AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .addr_i (store_addr),
    .data_i (store_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      ok_q <= step_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_ok_o  = ok_q;

endmodule

### design/mspfp_payload_store.sv
// payload byte memory, write only from the parser
module mspfp_payload_store #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       data_i
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= data_i;
    end
  end

endmodule

### design/mspfp_parse_core.sv
// frame state machine, running check and length tracking
module mspfp_parse_core
  import mspfp_pkg::*;
#(
  parameter int MaxPayload = 256,
  parameter int AddrW      = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output logic             ok_o,
  output logic             store_we_o,
  output logic [AddrW-1:0] store_addr_o,
  output logic [7:0]       store_data_o
);

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhHdr     = 4'd1;
  localparam logic [3:0] PhV1Dir   = 4'd2;
  localparam logic [3:0] PhV1Size  = 4'd3;
  localparam logic [3:0] PhV1Id    = 4'd4;
  localparam logic [3:0] PhV1Data  = 4'd5;
  localparam logic [3:0] PhV1Chk   = 4'd6;
  localparam logic [3:0] PhV2Dir   = 4'd7;
  localparam logic [3:0] PhV2Flag  = 4'd8;
  localparam logic [3:0] PhV2IdLo  = 4'd9;
  localparam logic [3:0] PhV2IdHi  = 4'd10;
  localparam logic [3:0] PhV2LenLo = 4'd11;
  localparam logic [3:0] PhV2LenHi = 4'd12;
  localparam logic [3:0] PhV2Data  = 4'd13;
  localparam logic [3:0] PhV2Chk   = 4'd14;

  localparam logic [16:0] MaxLen = 17'(MaxPayload);

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  check_q, check_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic        too_long_q, too_long_d;

  logic [15:0] count_inc;
  logic        last_data;
  logic [15:0] v2_len;
  logic [7:0]  crc_next;

  assign count_inc = count_q + 16'd1;
  assign last_data = count_inc >= length_q;
  assign v2_len    = {byte_i, length_q[7:0]};
  assign crc_next  = crc8_step(check_q, byte_i);

  always_comb begin
    phase_d      = phase_q;
    check_d      = check_q;
    length_d     = length_q;
    count_d      = count_q;
    too_long_d   = too_long_q;
    ok_o         = 1'b0;
    store_we_o   = 1'b0;
    store_addr_o = count_q[AddrW-1:0];
    store_data_o = byte_i;
    unique case (phase_q)
      PhIdle: begin
        if (byte_i == CharDollar) phase_d = PhHdr;
      end
      PhHdr: begin
        if (byte_i == CharM) begin
          phase_d = PhV1Dir;
        end else if (byte_i == CharX) begin
          phase_d = PhV2Dir;
        end else begin
          phase_d = (byte_i == CharDollar) ? PhHdr : PhIdle;
        end
      end
      PhV1Dir: begin
        if (byte_i == CharGt) phase_d = PhV1Size;
        else phase_d = (byte_i == CharDollar) ? PhHdr : PhIdle;
      end
      PhV1Size: begin
        length_d   = {8'h00, byte_i};
        check_d    = byte_i;
        count_d    = 16'd0;
        too_long_d = {9'h000, byte_i} > MaxLen;
        phase_d    = PhV1Id;
      end
      PhV1Id: begin
        check_d = check_q ^ byte_i;
        phase_d = (length_q == 16'd0) ? PhV1Chk : PhV1Data;
      end
      PhV1Data: begin
        check_d    = check_q ^ byte_i;
        store_we_o = !too_long_q && ({1'b0, count_q} < MaxLen);
        count_d    = count_inc;
        if (last_data) phase_d = PhV1Chk;
      end
      PhV2Dir: begin
        if (byte_i == CharGt) phase_d = PhV2Flag;
        else phase_d = (byte_i == CharDollar) ? PhHdr : PhIdle;
      end
      PhV2Flag: begin
        check_d = crc8_step(8'h00, byte_i);
        phase_d = PhV2IdLo;
      end
      PhV2IdLo: begin
        check_d = crc_next;
        phase_d = PhV2IdHi;
      end
      PhV2IdHi: begin
        check_d = crc_next;
        phase_d = PhV2LenLo;
      end
      PhV2LenLo: begin
        check_d  = crc_next;
        length_d = {8'h00, byte_i};
        phase_d  = PhV2LenHi;
      end
      PhV2LenHi: begin
        check_d    = crc_next;
        length_d   = v2_len;
        count_d    = 16'd0;
        too_long_d = {1'b0, v2_len} > MaxLen;
        phase_d    = (v2_len == 16'd0) ? PhV2Chk : PhV2Data;
      end
      PhV2Data: begin
        check_d    = crc_next;
        store_we_o = !too_long_q && ({1'b0, count_q} < MaxLen);
        count_d    = count_inc;
        if (last_data) phase_d = PhV2Chk;
      end
      PhV1Chk, PhV2Chk: begin
        ok_o    = (byte_i == check_q) && !too_long_q;
        phase_d = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
    store_we_o = store_we_o && step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      check_q    <= 8'h00;
      length_q   <= 16'd0;
      count_q    <= 16'd0;
      too_long_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      check_q    <= check_d;
      length_q   <= length_d;
      count_q    <= count_d;
      too_long_q <= too_long_d;
    end
  end

  ok_only_in_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_o |-> (phase_q == PhV1Chk || phase_q == PhV2Chk))
    else $error("frame good outside a checksum byte");

  chk_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PhV1Chk || phase_q == PhV2Chk) |=> phase_q == PhIdle)
    else $error("checksum byte did not end the frame");

  no_store_when_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we_o |-> !too_long_q && (phase_q == PhV1Data || phase_q == PhV2Data))
    else $error("payload write outside an accepted payload");

endmodule
